### rtl/ftrm_pkg.sv
// Package for the fan tacho RPM meter: operation codes, register indexes
// and fixed constants. No dependencies.
package ftrm_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_PPR     = 2'd0,
    IDX_WINDOW  = 2'd1,
    IDX_STALL   = 2'd2
  } ftrm_cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [3:0]  PPR_RESET    = 4'd2;
  localparam logic [15:0] WINDOW_RESET = 16'd1000;
  localparam logic [15:0] STALL_RESET  = 16'd1000;

  // Speed arithmetic.
  localparam int          RPM_W     = 16;
  localparam int          PPR_W     = 4;
  localparam logic [15:0] RPM_SCALE = 16'd60000;
  localparam logic [15:0] RPM_MAX   = 16'hFFFF;

  // What the back end must do for one accepted poll.
  typedef enum logic [1:0] {
    OP_OPEN = 2'd0,  // window still open, report current speed
    OP_KEEP = 2'd1,  // window closed without pulses, speed kept
    OP_ZERO = 2'd2,  // window closed without pulses, fan stalled
    OP_DIV  = 2'd3   // window closed with pulses, compute new speed
  } ftrm_op_e;

endpackage

### rtl/ftrm_fifo.sv
// Small register FIFO that decouples the poll classifier from the speed
// calculator. Generic; no package dependencies.
module ftrm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  // Pointer and fill-level update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset; an entry is read only after it was written.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/ftrm_front.sv
// Front end of the fan tacho RPM meter: edge detection, pulse counting and
// window bookkeeping per poll. Depends on ftrm_pkg.
module ftrm_front #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   tacho_level_i,
  input  logic [31:0]            now_ms_i,
  input  logic [15:0]            window_ms_i,
  input  logic [15:0]            stall_timeout_ms_i,
  input  logic                   push_ready_i,
  output logic                   push_valid_o,
  output ftrm_pkg::ftrm_op_e     op_o,
  output logic [COUNT_WIDTH-1:0] count_o,
  output logic [TIME_WIDTH-1:0]  elapsed_o
);
  import ftrm_pkg::*;

  logic                   prev_level_q, prev_level_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [TIME_WIDTH-1:0]  last_pulse_q, last_pulse_d;
  logic [TIME_WIDTH-1:0]  win_start_q, win_start_d;

  logic                   accept;
  logic                   fell;
  logic [TIME_WIDTH-1:0]  now_t;
  logic [COUNT_WIDTH-1:0] count_new;
  logic [TIME_WIDTH-1:0]  last_new;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [TIME_WIDTH-1:0]  age;
  logic [15:0]            win_eff;
  logic                   closed;
  ftrm_op_e               op;

  assign accept       = in_valid_i & push_ready_i;
  assign push_valid_o = in_valid_i;
  assign now_t        = TIME_WIDTH'(now_ms_i);
  assign win_eff      = (window_ms_i == '0) ? 16'd1 : window_ms_i;

  // A high-to-low change of the tacho line is one pulse; the counter saturates.
  assign fell      = prev_level_q & ~tacho_level_i;
  assign count_new = (fell && (count_q != '1)) ? count_q + 1'b1 : count_q;
  assign last_new  = fell ? now_t : last_pulse_q;

  // Window close test and stall test on wrapping time differences.
  assign elapsed = now_t - win_start_q;
  assign age     = now_t - last_new;
  assign closed  = (elapsed >= TIME_WIDTH'(win_eff));

  always_comb begin
    if (!closed) begin
      op = OP_OPEN;
    end else if (count_new != '0) begin
      op = OP_DIV;
    end else if (age > TIME_WIDTH'(stall_timeout_ms_i)) begin
      op = OP_ZERO;
    end else begin
      op = OP_KEEP;
    end
  end

  assign op_o      = op;
  assign count_o   = count_new;
  assign elapsed_o = elapsed;

  // Next state on an accepted poll.
  always_comb begin
    prev_level_d = prev_level_q;
    count_d      = count_q;
    last_pulse_d = last_pulse_q;
    win_start_d  = win_start_q;
    if (accept) begin
      prev_level_d = tacho_level_i;
      last_pulse_d = last_new;
      count_d      = (op == OP_DIV) ? '0 : count_new;
      if (closed) begin
        win_start_d = now_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      count_q      <= '0;
      last_pulse_q <= '0;
      win_start_q  <= '0;
    end else begin
      prev_level_q <= prev_level_d;
      count_q      <= count_d;
      last_pulse_q <= last_pulse_d;
      win_start_q  <= win_start_d;
    end
  end

endmodule

### rtl/ftrm_back.sv
// Back end of the fan tacho RPM meter: speed register, serial restoring
// divider and the output register. Depends on ftrm_pkg.
module ftrm_back #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  ftrm_pkg::ftrm_op_e     job_op_i,
  input  logic [COUNT_WIDTH-1:0] job_count_i,
  input  logic [TIME_WIDTH-1:0]  job_elapsed_i,
  input  logic [3:0]             pulses_per_rev_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [15:0]            rpm_o,
  output logic                   window_closed_o
);
  import ftrm_pkg::*;

  localparam int NUM_W  = COUNT_WIDTH + RPM_W;
  localparam int DEN_W  = TIME_WIDTH + PPR_W;
  localparam int STEP_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic                   out_valid_q;
  logic [RPM_W-1:0]       rpm_q;
  logic                   closed_q;
  logic [RPM_W-1:0]       speed_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [TIME_WIDTH-1:0]  elapsed_q;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [DEN_W-1:0]       den_q;
  logic [DEN_W-1:0]       rem_q, rem_d;
  logic [STEP_W-1:0]      step_q;

  logic                   out_free;
  logic [PPR_W-1:0]       ppr_eff;
  logic [DEN_W:0]         trial;
  logic [DEN_W:0]         diff;
  logic                   fits;
  logic [RPM_W-1:0]       rpm_sat;

  assign out_free        = ~out_valid_q | out_ready_i;
  assign job_ready_o     = (state_q == ST_IDLE) & out_free;
  assign out_valid_o     = out_valid_q;
  assign rpm_o           = rpm_q;
  assign window_closed_o = closed_q;
  assign ppr_eff         = (pulses_per_rev_i == '0) ? PPR_W'(1) : pulses_per_rev_i;

  // One restoring division step: the quotient bits shift into num_q.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign rem_d = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign num_d = {num_q[NUM_W-2:0], fits};

  // Quotients beyond 16 bits saturate.
  assign rpm_sat = (|num_q[NUM_W-1:RPM_W]) ? RPM_MAX : num_q[RPM_W-1:0];

  // Sequencer, datapath and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rpm_q       <= '0;
      closed_q    <= 1'b0;
      speed_q     <= '0;
      count_q     <= '0;
      elapsed_q   <= '0;
      num_q       <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i && out_free) begin
            case (job_op_i)
              OP_DIV: begin
                count_q   <= job_count_i;
                elapsed_q <= job_elapsed_i;
                state_q   <= ST_MUL;
              end
              OP_ZERO: begin
                speed_q     <= '0;
                rpm_q       <= '0;
                closed_q    <= 1'b1;
                out_valid_q <= 1'b1;
              end
              OP_KEEP: begin
                rpm_q       <= speed_q;
                closed_q    <= 1'b1;
                out_valid_q <= 1'b1;
              end
              default: begin
                rpm_q       <= speed_q;
                closed_q    <= 1'b0;
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          // Dividend is pulses times 60000, divisor is pulses per rev times ms.
          num_q   <= NUM_W'(count_q) * NUM_W'(RPM_SCALE);
          den_q   <= DEN_W'(ppr_eff) * DEN_W'(elapsed_q);
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          num_q  <= num_d;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(NUM_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            speed_q     <= rpm_sat;
            rpm_q       <= rpm_sat;
            closed_q    <= 1'b1;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/fan_tacho_rpm_meter_unit.sv
// Top level of the fan tacho RPM meter: configuration registers and the
// front end, queue and back end. Depends on ftrm_pkg and the ftrm_* modules.
//
// Each request is one poll of the tacho line with its millisecond time and
// gives exactly one result: the current speed and whether this poll closed
// a measurement window. A front end counts falling edges and classifies the
// poll at once, so polls are taken one per cycle while a two-entry queue
// has room. Results of polls that leave the window open, or close it with
// no pulses, go straight to the output register when the back end takes
// them. A poll that closes a window with pulses goes through these back-end
// steps in order: taking the job, one multiply, COUNT_WIDTH + 16 steps of
// the bit-serial restoring divider, and loading the output register; that
// divider sets the rate. Speed saturates at 65535 rpm.
// Configuration is written through a plain write port with no read-back.
module fan_tacho_rpm_meter_unit #(
  parameter int TIME_WIDTH  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            tacho_level_i,
  input  logic [31:0]                     now_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [15:0]                     rpm_o,
  output logic                            window_closed_o
);
  import ftrm_pkg::*;

  localparam int JOB_W = $bits(ftrm_op_e) + COUNT_WIDTH + TIME_WIDTH;

  logic [PPR_W-1:0] ppr_q;
  logic [15:0]      window_q;
  logic [15:0]      stall_q;

  logic                   push_valid, push_ready;
  ftrm_op_e               push_op;
  logic [COUNT_WIDTH-1:0] push_count;
  logic [TIME_WIDTH-1:0]  push_elapsed;
  logic [JOB_W-1:0]       push_data;

  logic                   job_valid, job_ready;
  logic [JOB_W-1:0]       job_data;
  ftrm_op_e               job_op;
  logic [COUNT_WIDTH-1:0] job_count;
  logic [TIME_WIDTH-1:0]  job_elapsed;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q    <= PPR_RESET;
      window_q <= WINDOW_RESET;
      stall_q  <= STALL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        IDX_PPR:    ppr_q    <= cfg_wdata_i[PPR_W-1:0];
        IDX_WINDOW: window_q <= cfg_wdata_i;
        IDX_STALL:  stall_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = push_ready;

  ftrm_front #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .tacho_level_i      (tacho_level_i),
    .now_ms_i           (now_ms_i),
    .window_ms_i        (window_q),
    .stall_timeout_ms_i (stall_q),
    .push_ready_i       (push_ready),
    .push_valid_o       (push_valid),
    .op_o               (push_op),
    .count_o            (push_count),
    .elapsed_o          (push_elapsed)
  );

  assign push_data = {push_op, push_count, push_elapsed};

  ftrm_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (job_valid),
    .rd_ready_i (job_ready),
    .rd_data_o  (job_data)
  );

  assign job_op      = ftrm_op_e'(job_data[JOB_W-1 -: $bits(ftrm_op_e)]);
  assign job_count   = job_data[TIME_WIDTH +: COUNT_WIDTH];
  assign job_elapsed = job_data[TIME_WIDTH-1:0];

  ftrm_back #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (job_valid),
    .job_ready_o      (job_ready),
    .job_op_i         (job_op),
    .job_count_i      (job_count),
    .job_elapsed_i    (job_elapsed),
    .pulses_per_rev_i (ppr_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rpm_o            (rpm_o),
    .window_closed_o  (window_closed_o)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// Testbench for fan_tacho_rpm_meter_unit: a queue-fed request driver, a result
// monitor and an in-order speed predictor. Depends on ftrm_pkg and the RTL.
module tb;
  import ftrm_pkg::*;

  localparam int unsigned IDLE_PCT       = 32;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic        level;
    logic [31:0] stamp;
  } poll_t;

  typedef struct packed {
    logic [15:0] rpm;
    logic        closed;
  } reading_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic                  tacho_level_i   = 1'b1;
  logic [31:0]           now_ms_i        = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [15:0]           rpm_o;
  logic                  window_closed_o;

  // Polls waiting to be offered and readings waiting to come out.
  poll_t    polls_to_send[$];
  reading_t readings_due[$];

  // Stimulus controls, written by the sequence at a falling edge only.
  logic rx_hold_req = 1'b0;
  logic no_idle     = 1'b0;

  int unsigned mismatches = 0;

  // Predicted register and meter state.
  logic [3:0]  m_ppr       = PPR_RESET;
  logic [15:0] m_window    = WINDOW_RESET;
  logic [15:0] m_stall     = STALL_RESET;
  logic        m_level     = 1'b1;
  logic [15:0] m_pulses    = '0;
  logic [31:0] m_last_edge = '0;
  logic [31:0] m_win_start = '0;
  logic [15:0] m_speed     = '0;

  // Random poll generator state.
  logic [31:0] gen_time   = '0;
  logic        gen_level  = 1'b1;
  int unsigned quiet_left = 0;

  fan_tacho_rpm_meter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tacho_level_i  (tacho_level_i),
    .now_ms_i       (now_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .rpm_o          (rpm_o),
    .window_closed_o(window_closed_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Advances the predicted meter by one poll and returns the reading it gives.
  function automatic reading_t meter_after_poll(logic level, logic [31:0] stamp);
    reading_t    r;
    logic [31:0] elapsed;
    logic [31:0] age;
    logic [31:0] win_eff;
    logic [3:0]  ppr_eff;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    win_eff  = (m_window == '0) ? 32'd1 : 32'(m_window);
    ppr_eff  = (m_ppr == '0) ? 4'd1 : m_ppr;
    r.closed = 1'b0;
    // A falling edge counts a pulse; a full counter only records the time.
    if (m_level && !level) begin
      if (m_pulses != '1) m_pulses = m_pulses + 16'd1;
      m_last_edge = stamp;
    end
    m_level = level;
    elapsed = stamp - m_win_start;
    if (elapsed >= win_eff) begin
      r.closed = 1'b1;
      if (m_pulses != '0) begin
        num      = 64'(m_pulses) * 64'(RPM_SCALE);
        den      = 64'(ppr_eff) * 64'(elapsed);
        quo      = num / den;
        m_speed  = (quo > 64'(RPM_MAX)) ? RPM_MAX : quo[15:0];
        m_pulses = '0;
      end else begin
        // The speed drops to zero only once the last pulse is strictly too old.
        age = stamp - m_last_edge;
        if (age > 32'(m_stall)) m_speed = '0;
      end
      m_win_start = stamp;
    end
    r.rpm = m_speed;
    return r;
  endfunction

  // Request driver: offers queued polls, idling at random between them.
  always @(posedge clk_i or negedge rst_ni) begin : poll_driver
    poll_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      tacho_level_i <= 1'b1;
      now_ms_i      <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (polls_to_send.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        nxt           = polls_to_send.pop_front();
        in_valid_i    <= 1'b1;
        tacho_level_i <= nxt.level;
        now_ms_i      <= nxt.stamp;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin : result_ready
    int unsigned hold_left;
    logic        hold_taken;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   = 0;
      hold_taken  = 1'b0;
    end else if (rx_hold_req && !hold_taken) begin
      hold_taken  = 1'b1;
      hold_left   = RX_HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predicts each accepted request and checks each accepted result in order.
  always @(posedge clk_i) begin : reading_check
    reading_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        readings_due.push_back(meter_after_poll(tacho_level_i, now_ms_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (readings_due.size() == 0) begin
          $error("result with no request pending: rpm %0d, window_closed %0b",
                 rpm_o, window_closed_o);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          if (rpm_o !== want.rpm) begin
            $error("rpm: expected %0d, actual %0d", want.rpm, rpm_o);
            mismatches++;
          end
          if (window_closed_o !== want.closed) begin
            $error("window_closed: expected %0b, actual %0b", want.closed,
                   window_closed_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  task automatic push_poll(logic level, logic [31:0] stamp);
    polls_to_send.push_back('{level: level, stamp: stamp});
  endtask

  // Holds the sender back until every request has been answered.
  task automatic wait_drained();
    @(negedge clk_i);
    while (polls_to_send.size() != 0 || in_valid_i || readings_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(ftrm_cfg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      IDX_PPR:    m_ppr = value[3:0];
      IDX_WINDOW: m_window = value;
      IDX_STALL:  m_stall = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] ppr, logic [15:0] window, logic [15:0] stall);
    wait_drained();
    write_reg(IDX_PPR, 16'(ppr));
    write_reg(IDX_WINDOW, window);
    write_reg(IDX_STALL, stall);
    @(negedge clk_i);
  endtask

  // Mostly a spinning fan with random timing, with quiet stretches, noise
  // and occasional jumps of the clock anywhere in its range.
  task automatic queue_random_polls(int unsigned n, int unsigned max_dt);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) gen_time = $urandom;
      else gen_time = gen_time + $urandom_range(max_dt);
      if (quiet_left != 0) begin
        quiet_left--;
        gen_level = 1'b1;
      end else if (r < 75) begin
        gen_level = ~gen_level;
      end else if (r < 97) begin
        gen_level = $urandom_range(1);
      end else begin
        quiet_left = $urandom_range(30, 5);
      end
      push_poll(gen_level, gen_time);
    end
  endtask

  task automatic random_phase(logic [3:0] ppr, logic [15:0] window, logic [15:0] stall,
                              int unsigned n, int unsigned max_dt);
    set_config(ppr, window, stall);
    gen_time = m_win_start;
    queue_random_polls(n, max_dt);
  endtask

  initial begin : sequence_main
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed polls at the reset settings.
    push_poll(1'b1, 32'd0);
    push_poll(1'b0, 32'd10);
    push_poll(1'b1, 32'd500);
    push_poll(1'b0, 32'd999);
    push_poll(1'b1, 32'd1000);       // closes with two pulses
    push_poll(1'b1, 32'd2000);       // no pulses, last one just past the timeout
    push_poll(1'b0, 32'd2500);
    push_poll(1'b1, 32'd2600);
    push_poll(1'b0, 32'd3000);       // pulse on the closing poll itself
    push_poll(1'b1, 32'd4000);       // no pulses, age equal to the timeout
    push_poll(1'b0, 32'd4001);
    push_poll(1'b1, 32'd4002);
    push_poll(1'b0, 32'd4003);
    push_poll(1'b1, 32'd4004);
    push_poll(1'b0, 32'd4005);
    push_poll(1'b0, 32'hFFFF_FFFF);  // huge elapsed time gives zero
    push_poll(1'b1, 32'h0000_0000);  // time wraps, window stays open
    push_poll(1'b0, 32'd999);        // closes across the wrap

    // Zero registers fall back to one; many pulses in 1 ms saturate.
    set_config(4'd0, 16'd0, 16'd0);
    push_poll(1'b1, 32'd5000);
    push_poll(1'b0, 32'd5000);
    push_poll(1'b1, 32'd5000);
    push_poll(1'b0, 32'd5000);
    push_poll(1'b1, 32'd5000);
    push_poll(1'b0, 32'd5001);
    push_poll(1'b1, 32'd5002);

    // Random phases; the first one also stalls the result side for long.
    random_phase(4'd2, 16'd20, 16'd40, 125, 8);
    rx_hold_req = 1'b1;
    random_phase(4'd1, 16'd1, 16'd0, 125, 3);
    no_idle = 1'b1;
    random_phase(4'd8, 16'd100, 16'd300, 125, 60);
    no_idle = 1'b0;
    random_phase(4'd15, 16'd7, 16'd5, 125, 10);
    random_phase(4'd0, 16'd0, 16'd65535, 125, 2);
    random_phase(4'd3, 16'd65535, 16'd65535, 125, 20000);
    random_phase(4'd5, 16'd50, 16'd0, 125, 200);

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ftrm_pkg.sv
rtl/ftrm_fifo.sv
rtl/ftrm_front.sv
rtl/ftrm_back.sv
rtl/fan_tacho_rpm_meter_unit.sv
dv/tb.sv
